// ----- rtl/m3i_pkg.sv -----
`timescale 1ns / 1ps
package m3i_pkg;

    localparam int WORD_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int THRESH_WIDTH = 31;
    localparam int ELEMS        = 9;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] a00;
        logic signed [WORD_WIDTH-1:0] a01;
        logic signed [WORD_WIDTH-1:0] a02;
        logic signed [WORD_WIDTH-1:0] a10;
        logic signed [WORD_WIDTH-1:0] a11;
        logic signed [WORD_WIDTH-1:0] a12;
        logic signed [WORD_WIDTH-1:0] a20;
        logic signed [WORD_WIDTH-1:0] a21;
        logic signed [WORD_WIDTH-1:0] a22;
    } mat_in_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] r00;
        logic signed [WORD_WIDTH-1:0] r01;
        logic signed [WORD_WIDTH-1:0] r02;
        logic signed [WORD_WIDTH-1:0] r10;
        logic signed [WORD_WIDTH-1:0] r11;
        logic signed [WORD_WIDTH-1:0] r12;
        logic signed [WORD_WIDTH-1:0] r20;
        logic signed [WORD_WIDTH-1:0] r21;
        logic signed [WORD_WIDTH-1:0] r22;
        logic signed [WORD_WIDTH-1:0] det_value;
        logic                         singular;
    } mat_out_t;

endpackage

// ----- rtl/m3i_front.sv -----
`timescale 1ns / 1ps
module m3i_front #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  m3i_pkg::mat_in_t                       mat,
    input  logic [m3i_pkg::THRESH_WIDTH-1:0]       thresh,
    output logic [2*m3i_pkg::WORD_WIDTH+2*FRAC_BITS-1:0] num_mag [m3i_pkg::ELEMS],
    output logic                                   num_neg [m3i_pkg::ELEMS],
    output logic [3*m3i_pkg::WORD_WIDTH-1:0]       den_mag,
    output logic                                   sing,
    output logic signed [m3i_pkg::WORD_WIDTH-1:0]  det_sat
);
    localparam int W  = m3i_pkg::WORD_WIDTH;
    localparam int N  = m3i_pkg::ELEMS;
    localparam int S2 = 2 * FRAC_BITS;
    localparam int DW = 3 * W + 3;
    localparam int NW = 2 * W + S2;

    logic signed [W-1:0]    e [N];
    logic signed [W-1:0]    e1_reg [3];
    logic signed [W-1:0]    e2_reg [3];
    logic signed [2*W-1:0]  pa_reg [N];
    logic signed [2*W-1:0]  pb_reg [N];
    logic signed [2*W:0]    adj_reg [N];
    logic signed [2*W:0]    adj3_reg [N];
    logic signed [2*W:0]    adj4_reg [N];
    logic signed [2*W:0]    plo_reg [3];
    logic signed [2*W:0]    phi_reg [3];
    logic signed [DW-1:0]   det_reg;
    logic signed [DW-1:0]   det_half;
    logic signed [DW-1:0]   rnd;
    logic [DW-1:0]          rnd_mag;
    logic [DW-1:0]          det_abs;
    logic                   in_rng;
    logic [2*W-1:0]         adj_abs [N];
    logic [NW-1:0]          num_reg [N];
    logic                   neg_reg [N];
    logic [3*W-1:0]         den_reg;
    logic                   sing_reg;
    logic signed [W-1:0]    dsat_reg;

    // row-major element order, cofactor pairs follow the adjugate layout
    localparam int IA0 [N] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int IA1 [N] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int IB0 [N] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int IB1 [N] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    assign e[0] = mat.a00;
    assign e[1] = mat.a01;
    assign e[2] = mat.a02;
    assign e[3] = mat.a10;
    assign e[4] = mat.a11;
    assign e[5] = mat.a12;
    assign e[6] = mat.a20;
    assign e[7] = mat.a21;
    assign e[8] = mat.a22;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                pa_reg[k]   <= e[IA0[k]] * e[IA1[k]];
                pb_reg[k]   <= e[IB0[k]] * e[IB1[k]];
                adj_reg[k]  <= (2*W+1)'(pa_reg[k]) - (2*W+1)'(pb_reg[k]);
                adj3_reg[k] <= adj_reg[k];
                adj4_reg[k] <= adj3_reg[k];
            end
            // det partials split the wide cofactor into low and high halves
            for (int j = 0; j < 3; j++)
            begin
                e1_reg[j]  <= e[j];
                e2_reg[j]  <= e1_reg[j];
                plo_reg[j] <= e2_reg[j] * $signed({1'b0, adj_reg[3*j][W-1:0]});
                phi_reg[j] <= e2_reg[j] * $signed(adj_reg[3*j][2*W:W]);
            end
            det_reg <= (DW'(phi_reg[0]) <<< W) + DW'(plo_reg[0])
                     + (DW'(phi_reg[1]) <<< W) + DW'(plo_reg[1])
                     + (DW'(phi_reg[2]) <<< W) + DW'(plo_reg[2]);
            for (int k = 0; k < N; k++)
            begin
                num_reg[k] <= {adj_abs[k], {S2{1'b0}}};
                neg_reg[k] <= adj4_reg[k][2*W] ^ det_reg[DW-1];
            end
            den_reg  <= det_abs[3*W-1:0];
            sing_reg <= rnd_mag <= DW'(thresh);
            dsat_reg <= in_rng ? rnd[W-1:0]
                      : (rnd[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
        end
    end

    always_comb
    begin
        det_half = det_reg + $signed(DW'(1) << (S2 - 1));
        rnd      = det_half >>> S2;
        rnd_mag  = rnd[DW-1] ? DW'(-rnd) : DW'(rnd);
        det_abs  = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        in_rng   = (&rnd[DW-1:W-1]) | ~(|rnd[DW-1:W-1]);
        // cofactor magnitude never exceeds 2^(2W-1), so 2W bits hold it
        for (int k = 0; k < N; k++)
            adj_abs[k] = adj4_reg[k][2*W] ? (2*W)'(-adj4_reg[k]) : (2*W)'(adj4_reg[k]);
    end

    assign num_mag = num_reg;
    assign num_neg = neg_reg;
    assign den_mag = den_reg;
    assign sing    = sing_reg;
    assign det_sat = dsat_reg;

endmodule

// ----- rtl/m3i_div_lane.sv -----
`timescale 1ns / 1ps
module m3i_div_lane #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [2*m3i_pkg::WORD_WIDTH+2*FRAC_BITS-1:0]  num_mag,
    input  logic                                          num_neg,
    input  logic [3*m3i_pkg::WORD_WIDTH-1:0]              den_mag,
    input  logic                                          sing,
    output logic signed [m3i_pkg::WORD_WIDTH-1:0]         quo
);
    localparam int W   = m3i_pkg::WORD_WIDTH;
    localparam int NW  = 2 * W + 2 * FRAC_BITS;
    localparam int DMW = 3 * W;
    localparam int CW  = (NW > DMW + W) ? NW + 1 : DMW + W + 1;

    logic [CW-1:0]  r_reg   [W+1];
    logic [W-1:0]   q_reg   [W+1];
    logic [DMW-1:0] d_reg   [W+1];
    logic           ovf_reg [W+1];
    logic           neg_reg [W+1];
    logic           sing_reg[W+1];
    logic [CW-1:0]  trial   [W+1];
    logic [W:0]     q_rnd;
    logic           sat;
    logic signed [W-1:0] quo_next;
    logic signed [W-1:0] quo_reg;

    always_comb
    begin
        trial[0] = '0;
        for (int s = 1; s <= W; s++)
            trial[s] = CW'(d_reg[s-1]) << (W - s);
        q_rnd = {1'b0, q_reg[W]} + (W+1)'(({r_reg[W][CW-2:0], 1'b0}) >= CW'(d_reg[W]));
        sat   = ovf_reg[W] | (neg_reg[W] ? (q_rnd > (W+1)'(1) << (W - 1))
                                         : (q_rnd >= (W+1)'(1) << (W - 1)));
        if (sing_reg[W])
            quo_next = '0;
        else if (sat)
            quo_next = neg_reg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            quo_next = neg_reg[W] ? -q_rnd[W-1:0] : q_rnd[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= CW'(num_mag);
            q_reg[0]    <= '0;
            d_reg[0]    <= den_mag;
            ovf_reg[0]  <= CW'(num_mag) >= (CW'(den_mag) << W);
            neg_reg[0]  <= num_neg;
            sing_reg[0] <= sing;
            // one quotient bit per stage, msb first
            for (int s = 1; s <= W; s++)
            begin
                if (r_reg[s-1] >= trial[s])
                begin
                    r_reg[s] <= r_reg[s-1] - trial[s];
                    q_reg[s] <= q_reg[s-1] | (W'(1) << (W - s));
                end
                else
                begin
                    r_reg[s] <= r_reg[s-1];
                    q_reg[s] <= q_reg[s-1];
                end
                d_reg[s]    <= d_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ----- rtl/matrix3x3_inverse_core.sv -----
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, signed fixed point
// in channel (in_valid/in_ready/in_data): one matrix per beat, row-major
// out channel (out_valid/out_ready/out_data): nine inverse elements,
// the rounded determinant and the singular flag, one beat per matrix
// cfg channel (cfg_valid/cfg_ready/cfg_data): singular threshold, always
// ready; write it only while no matrix is in flight
// each result passes the front stages, then the nine divider lanes that
// resolve one quotient bit per stage, then the output register
// throughput is one matrix per cycle unless the pipeline holds; all lanes advance together
// when the receiver stalls, results keep flowing until the output register
// holds one and another has reached the end of the lanes; the whole
// pipeline then holds and in_ready drops
// reset clears all valid flags and the threshold to zero
module matrix3x3_inverse_core #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  m3i_pkg::mat_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output m3i_pkg::mat_out_t                     out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [m3i_pkg::THRESH_WIDTH-1:0]      cfg_data
);
    localparam int W  = m3i_pkg::WORD_WIDTH;
    localparam int N  = m3i_pkg::ELEMS;
    localparam int NW = 2 * W + 2 * FRAC_BITS;
    localparam int LD = W + 2;
    localparam int P  = 5 + LD;

    logic                              en;
    logic [P-1:0]                      vld_reg, vld_next;
    logic                              out_valid_reg, out_valid_next;
    m3i_pkg::mat_out_t                 out_reg;
    logic [m3i_pkg::THRESH_WIDTH-1:0]  thr_reg;
    logic [NW-1:0]                     num_mag [N];
    logic                              num_neg [N];
    logic [3*W-1:0]                    den_mag;
    logic                              sing;
    logic signed [W-1:0]               det_sat;
    logic signed [W-1:0]               quo [N];
    logic signed [W-1:0]               det_dly_reg [LD];
    logic                              sing_dly_reg [LD];

    assign en        = !vld_reg[P-1] || !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        vld_next       = en ? {vld_reg[P-2:0], in_valid} : vld_reg;
        out_valid_next = (en && vld_reg[P-1]) ? 1'b1
                       : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= '0;
        end
        else
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                thr_reg <= cfg_data;
        end
    end

    m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk     (clk),
        .en      (en),
        .mat     (in_data),
        .thresh  (thr_reg),
        .num_mag (num_mag),
        .num_neg (num_neg),
        .den_mag (den_mag),
        .sing    (sing),
        .det_sat (det_sat)
    );

    for (genvar k = 0; k < N; k++)
    begin : g_lane
        m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk     (clk),
            .en      (en),
            .num_mag (num_mag[k]),
            .num_neg (num_neg[k]),
            .den_mag (den_mag),
            .sing    (sing),
            .quo     (quo[k])
        );
    end

    // determinant and flag ride alongside the divider lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_dly_reg[0]  <= det_sat;
            sing_dly_reg[0] <= sing;
            for (int s = 1; s < LD; s++)
            begin
                det_dly_reg[s]  <= det_dly_reg[s-1];
                sing_dly_reg[s] <= sing_dly_reg[s-1];
            end
            if (vld_reg[P-1])
            begin
                out_reg.r00       <= quo[0];
                out_reg.r01       <= quo[1];
                out_reg.r02       <= quo[2];
                out_reg.r10       <= quo[3];
                out_reg.r11       <= quo[4];
                out_reg.r12       <= quo[5];
                out_reg.r20       <= quo[6];
                out_reg.r21       <= quo[7];
                out_reg.r22       <= quo[8];
                out_reg.det_value <= det_dly_reg[LD-1];
                out_reg.singular  <= sing_dly_reg[LD-1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/m3i_checker.sv -----
`timescale 1ns / 1ps
module m3i_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  m3i_pkg::mat_out_t out_data
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out_data changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.singular |-> (out_data.r00 == '0 && out_data.r11 == '0
            && out_data.r22 == '0 && out_data.r01 == '0 && out_data.r12 == '0))
        else $error("singular result with nonzero elements");

endmodule

bind matrix3x3_inverse_core m3i_checker u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/sv/tb_matrix3x3_inverse_core.sv -----
`timescale 1ns / 1ps
module tb_matrix3x3_inverse_core;

    localparam int SETTLE_CYCLES = 60;
    localparam int WW = m3i_pkg::WORD_WIDTH;
    localparam int FB = m3i_pkg::FRAC_BITS;
    localparam int TW = m3i_pkg::THRESH_WIDTH;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    m3i_pkg::mat_in_t        in_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    m3i_pkg::mat_out_t       out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [TW-1:0]           cfg_data = '0;

    m3i_pkg::mat_in_t        pending_mats[$];
    m3i_pkg::mat_out_t       expected_inv[$];
    logic [TW-1:0]           sing_thresh = '0;
    int                      errors = 0;
    bit                      in_beat_done = 0;
    bit                      calm = 0;
    bit                      long_hold = 0;
    int                      in_gap = 0;
    int                      out_gap = 0;

    matrix3x3_inverse_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [WW-1:0] sat_word(logic signed [129:0] v);
        if (v > 130'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -130'sd2147483648)
            return 32'sh80000000;
        return v[WW-1:0];
    endfunction

    // rounded to nearest, ties away from zero
    function automatic logic signed [WW-1:0] div_round(logic signed [129:0] n,
                                                       logic signed [129:0] d);
        logic [129:0]        nm;
        logic [129:0]        dm;
        logic [129:0]        q;
        logic [129:0]        rem;
        logic signed [129:0] sq;
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        q = nm / dm;
        rem = nm % dm;
        if ((rem << 1) >= dm)
            q = q + 1;
        sq = ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
        return sat_word(sq);
    endfunction

    function automatic m3i_pkg::mat_out_t invert_matrix(m3i_pkg::mat_in_t m,
                                                        logic [TW-1:0] thr);
        longint              e[9];
        longint              cof[9];
        logic signed [129:0] w0, w1, w2, c0, c3, c6;
        logic signed [129:0] det;
        logic signed [129:0] rnd;
        logic signed [129:0] mag;
        logic signed [129:0] num;
        logic signed [WW-1:0] r[9];
        bit                  sing;
        m3i_pkg::mat_out_t   o;
        e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        // each cofactor fits in 64 bits for any pair of 32-bit products
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        w0 = e[0];
        w1 = e[1];
        w2 = e[2];
        c0 = cof[0];
        c3 = cof[3];
        c6 = cof[6];
        det = w0 * c0 + w1 * c3 + w2 * c6;
        rnd = (det + (130'sd1 <<< (2 * FB - 1))) >>> (2 * FB);
        mag = rnd < 0 ? -rnd : rnd;
        sing = mag <= $signed({99'd0, thr});
        for (int k = 0; k < 9; k++)
        begin
            num = cof[k];
            num = num <<< (2 * FB);
            r[k] = sing ? '0 : div_round(num, det);
        end
        o.r00 = r[0];
        o.r01 = r[1];
        o.r02 = r[2];
        o.r10 = r[3];
        o.r11 = r[4];
        o.r12 = r[5];
        o.r20 = r[6];
        o.r21 = r[7];
        o.r22 = r[8];
        o.det_value = sat_word(rnd);
        o.singular = sing;
        return o;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("error at %0t: %s got %0d want %0d", $time, field, got, want);
        errors++;
    endtask

    task automatic compare_result(m3i_pkg::mat_out_t got, m3i_pkg::mat_out_t want);
        if (got.r00 !== want.r00) report_mismatch("r00", got.r00, want.r00);
        if (got.r01 !== want.r01) report_mismatch("r01", got.r01, want.r01);
        if (got.r02 !== want.r02) report_mismatch("r02", got.r02, want.r02);
        if (got.r10 !== want.r10) report_mismatch("r10", got.r10, want.r10);
        if (got.r11 !== want.r11) report_mismatch("r11", got.r11, want.r11);
        if (got.r12 !== want.r12) report_mismatch("r12", got.r12, want.r12);
        if (got.r20 !== want.r20) report_mismatch("r20", got.r20, want.r20);
        if (got.r21 !== want.r21) report_mismatch("r21", got.r21, want.r21);
        if (got.r22 !== want.r22) report_mismatch("r22", got.r22, want.r22);
        if (got.det_value !== want.det_value)
            report_mismatch("det_value", got.det_value, want.det_value);
        if (got.singular !== want.singular)
            report_mismatch("singular", got.singular, want.singular);
    endtask

    // monitor: sample every handshake at the rising edge
    always @(posedge clk)
    begin
        in_beat_done = 0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sing_thresh = cfg_data;
            if (in_valid && in_ready)
            begin
                expected_inv.push_back(invert_matrix(in_data, sing_thresh));
                in_beat_done = 1;
            end
            if (out_valid && out_ready)
            begin
                // a result beat with none expected
                if (expected_inv.size() == 0)
                    report_mismatch("out beat", 1, 0);
                else
                    compare_result(out_data, expected_inv.pop_front());
            end
        end
    end

    // driver for the matrix channel
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_beat_done))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                in_gap = $urandom_range(1, 17) - 1;
                in_valid <= 1'b0;
            end
            else if (pending_mats.size() > 0)
            begin
                in_data <= pending_mats.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver side stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold)
                out_ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic signed [WW-1:0] rand_elem(int mode);
        case (mode)
            0: return $signed(32'($urandom_range(0, 32'h40000))) - 32'sh20000;
            1: return $signed($urandom());
            2: return $signed(32'($urandom_range(0, 32'h200))) - 32'sh100;
            default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    function automatic m3i_pkg::mat_in_t rand_matrix();
        m3i_pkg::mat_in_t m;
        int      mode;
        int      pick;
        pick = $urandom_range(0, 19);
        mode = pick < 12 ? 0 : pick < 15 ? 1 : pick < 18 ? 2 : 3;
        m.a00 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a01 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a02 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a10 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a11 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a12 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a20 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a21 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        m.a22 = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
        // repeated row gives an exactly singular matrix
        if ($urandom_range(0, 15) == 0)
        begin
            m.a20 = m.a00;
            m.a21 = m.a01;
            m.a22 = m.a02;
        end
        return m;
    endfunction

    function automatic m3i_pkg::mat_in_t fill_matrix(logic signed [WW-1:0] d,
                                                     logic signed [WW-1:0] off);
        m3i_pkg::mat_in_t m;
        m = '{off, off, off, off, off, off, off, off, off};
        m.a00 = d;
        m.a11 = d;
        m.a22 = d;
        return m;
    endfunction

    task automatic queue_random(int n);
        repeat (n)
            pending_mats.push_back(rand_matrix());
    endtask

    task automatic wait_idle();
        while (pending_mats.size() != 0 || in_valid || expected_inv.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [TW-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: identity, scaled diagonals, zero, extremes, tiny determinants
        pending_mats.push_back(fill_matrix(32'sh10000, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh20000, 32'sh0));
        pending_mats.push_back(fill_matrix(-32'sh8000, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh0, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh7FFFFFFF, 32'sh7FFFFFFF));
        pending_mats.push_back(fill_matrix(32'sh80000000, 32'sh80000000));
        pending_mats.push_back(fill_matrix(32'sh7FFFFFFF, 32'sh80000000));
        pending_mats.push_back(fill_matrix(32'sh80000000, 32'sh7FFFFFFF));
        pending_mats.push_back(fill_matrix(32'sh80000000, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh7FFFFFFF, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh1, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh100, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh10000, 32'sh8000));
        pending_mats.push_back(fill_matrix(32'sh3, 32'sh1));
        pending_mats.push_back(fill_matrix(-32'sh1, -32'sh1));
        pending_mats.push_back('{32'sh10000, 32'sh20000, 32'sh30000,
                                 32'sh40000, 32'sh50000, 32'sh60000,
                                 32'sh70000, 32'sh80000, 32'sh90000});
        pending_mats.push_back('{32'sh0, 32'sh10000, 32'sh0,
                                 32'sh0, 32'sh0, 32'sh10000,
                                 32'sh10000, 32'sh0, 32'sh0});
        pending_mats.push_back('{32'sh30000, 32'sh0, 32'sh0,
                                 32'sh0, 32'sh30000, 32'sh0,
                                 32'sh0, 32'sh0, 32'sh30000});
        pending_mats.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                                 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                                 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
        pending_mats.push_back('{32'sh7FFFFFFF, 32'sh0, 32'sh0,
                                 32'sh0, 32'sh7FFFFFFF, 32'sh0,
                                 32'sh0, 32'sh0, 32'sh1});
        wait_idle();

        // receiver holds off while matrices keep coming, so the pipeline backs up
        long_hold = 1;
        queue_random(150);
        repeat (400) @(posedge clk);
        long_hold = 0;
        queue_random(250);
        wait_idle();

        write_threshold(31'h7FFFFFFF);
        queue_random(100);
        wait_idle();

        write_threshold(31'($urandom_range(0, 32'h20000)));
        queue_random(200);
        wait_idle();

        write_threshold(31'h10000);
        pending_mats.push_back(fill_matrix(32'sh10000, 32'sh0));
        pending_mats.push_back(fill_matrix(32'sh10001, 32'sh0));
        queue_random(150);
        wait_idle();

        write_threshold(31'($urandom()));
        queue_random(100);
        wait_idle();

        write_threshold(31'h0);
        calm = 1;
        queue_random(480);
        wait_idle();

        if (errors == 0)
            $display("matrix3x3_inverse_core: match");
        else
            $display("matrix3x3_inverse_core: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("matrix3x3_inverse_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_div_lane.sv
rtl/matrix3x3_inverse_core.sv
rtl/m3i_checker.sv
tb/sv/tb_matrix3x3_inverse_core.sv
